/* rtl/core/psv_pkg.sv */
// Shared types for the pursuit steering velocity block.
// Holds the request and response items and the side data carried by the arithmetic units.
// Depends on nothing.
package psv_pkg;

   typedef struct packed {
      logic signed [31:0] self_pos_x;
      logic signed [31:0] self_pos_y;
      logic signed [31:0] self_pos_z;
      logic        [30:0] max_speed;
      logic signed [31:0] goal_pos_x;
      logic signed [31:0] goal_pos_y;
      logic signed [31:0] goal_pos_z;
      logic signed [31:0] goal_vel_x;
      logic signed [31:0] goal_vel_y;
      logic signed [31:0] goal_vel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] steer_vel_x;
      logic signed [31:0] steer_vel_y;
      logic signed [31:0] steer_vel_z;
      logic               result_valid;
   } rsp_type;

   typedef struct packed {
      logic [2:0][32:0] d;
      logic [2:0][31:0] vel;
      logic [30:0]      ms;
   } geo_type;

   typedef struct packed {
      logic [2:0][30:0] e;
      logic [2:0]       neg;
      logic [30:0]      ms;
   } fin_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       ok;
   } tag_type;

endpackage

/* rtl/core/pursuit_steering_velocity.sv */
// Pursuit steering velocity: predicts where a moving target will be and steers toward it.
// Depends on psv_pkg, psv_sqrt and psv_div.
//
// The block accepts one item per clock cycle while its output buffer is not full, and
// returns one result item for each, in order. Every step is a register stage: the distance
// root takes 34 stages, the travel-time divider 34 + FRAC_BITS, the direction root 33 and
// the final dividers 63, and the rest of the datapath 12 + log2 of the shift range (6 by
// default). The whole pipeline holds while its two-entry output buffer is full. Zero max
// speed, or a predicted point at the pursuer, yields zero velocity with result_valid low.
module pursuit_steering_velocity #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psv_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psv_pkg::rsp_type rsp_payload
);
   localparam int PW   = 33 + FRAC_BITS;
   localparam int WBW  = PW + 32;
   localparam int TW   = PW + 34;
   localparam int MW   = TW - 1;
   localparam int SMAX = MW - 31;
   localparam int K    = $clog2(SMAX + 1);

   logic en;

   // Input register.
   logic             a_v_ff;
   psv_pkg::req_type a_req_ff;
   logic [31:0]      a_self [3];
   logic [31:0]      a_goal [3];
   logic [31:0]      a_vel  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_valid;
      end
      if (en) begin
         a_req_ff <= req_payload;
      end
   end

   always_comb begin
      a_self[0] = a_req_ff.self_pos_x;
      a_self[1] = a_req_ff.self_pos_y;
      a_self[2] = a_req_ff.self_pos_z;
      a_goal[0] = a_req_ff.goal_pos_x;
      a_goal[1] = a_req_ff.goal_pos_y;
      a_goal[2] = a_req_ff.goal_pos_z;
      a_vel[0]  = a_req_ff.goal_vel_x;
      a_vel[1]  = a_req_ff.goal_vel_y;
      a_vel[2]  = a_req_ff.goal_vel_z;
   end

   // Offset to the target and the magnitude of each of its components.
   logic             b_v_ff;
   psv_pkg::geo_type b_geo_ff;
   logic [32:0]      b_m_ff [3];
   logic [32:0]      b_d_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_d_in[i] = {a_goal[i][31], a_goal[i]} - {a_self[i][31], a_self[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            b_geo_ff.d[i]   <= b_d_in[i];
            b_geo_ff.vel[i] <= a_vel[i];
            b_m_ff[i]       <= b_d_in[i][32] ? 33'(-b_d_in[i]) : b_d_in[i];
         end
         b_geo_ff.ms <= a_req_ff.max_speed;
      end
   end

   // Squares and their sum.
   logic             c_v_ff;
   psv_pkg::geo_type c_geo_ff;
   logic [65:0]      c_sq_ff [3];
   logic             d_v_ff;
   psv_pkg::geo_type d_geo_ff;
   logic [65:0]      d_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c_sq_ff[i] <= 66'(b_m_ff[i]) * 66'(b_m_ff[i]);
         end
         c_geo_ff <= b_geo_ff;
         d_sum_ff <= c_sq_ff[0] + c_sq_ff[1] + c_sq_ff[2];
         d_geo_ff <= c_geo_ff;
      end
   end

   // Distance, then travel time.
   logic                        s1_v;
   logic [32:0]                 s1_root;
   logic [$bits(psv_pkg::geo_type)-1:0] s1_side;
   psv_pkg::geo_type            s1_geo;
   logic                        p_v;
   logic [PW-1:0]               p_quo;
   logic [$bits(psv_pkg::geo_type)-1:0] p_side;
   psv_pkg::geo_type            p_geo;

   psv_sqrt #(.XW(66), .SW($bits(psv_pkg::geo_type))) u_dist (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d_v_ff), .in_x(d_sum_ff), .in_side(d_geo_ff),
      .out_valid(s1_v), .out_root(s1_root), .out_side(s1_side)
   );

   assign s1_geo = s1_side;

   psv_div #(.NW(PW), .DW(31), .SW($bits(psv_pkg::geo_type))) u_period (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s1_v), .in_num({s1_root, {FRAC_BITS{1'b0}}}), .in_den(s1_geo.ms),
      .in_side(s1_side),
      .out_valid(p_v), .out_quo(p_quo), .out_side(p_side)
   );

   assign p_geo = p_side;

   // Target velocity times travel time, as two partial products.
   logic             e_v_ff;
   psv_pkg::geo_type e_geo_ff;
   logic [63:0]      e_plo_ff [3];
   logic [PW-1:0]    e_phi_ff [3];
   logic [31:0]      e_vmag_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_vmag_in[i] = p_geo.vel[i][31] ? 32'(-p_geo.vel[i]) : p_geo.vel[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= p_v;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e_plo_ff[i] <= 64'(e_vmag_in[i]) * 64'(p_quo[31:0]);
            e_phi_ff[i] <= PW'(e_vmag_in[i]) * PW'(p_quo[PW-1:32]);
         end
         e_geo_ff <= p_geo;
      end
   end

   logic             f_v_ff;
   psv_pkg::geo_type f_geo_ff;
   logic [WBW-1:0]   f_wb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= e_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            f_wb_ff[i] <= WBW'(e_plo_ff[i]) + (WBW'(e_phi_ff[i]) << 32);
         end
         f_geo_ff <= e_geo_ff;
      end
   end

   // Predicted point relative to the pursuer.
   logic                 g_v_ff;
   logic [30:0]          g_ms_ff;
   logic signed [TW-1:0] g_t_ff  [3];
   logic signed [TW-1:0] g_dsh_in [3];
   logic signed [TW-1:0] g_wb_in  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_dsh_in[i] = TW'($signed(f_geo_ff.d[i])) <<< FRAC_BITS;
         g_wb_in[i]  = TW'(f_wb_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en) begin
         g_v_ff <= f_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            g_t_ff[i] <= f_geo_ff.vel[i][31] ? g_dsh_in[i] - g_wb_in[i]
                                            : g_dsh_in[i] + g_wb_in[i];
         end
         g_ms_ff <= f_geo_ff.ms;
      end
   end

   // Magnitudes, then a common right shift until the largest fits in 31 bits.
   logic          nm_v_ff   [K+1];
   logic [MW-1:0] nm_mag_ff [K+1][3];
   logic [2:0]    nm_neg_ff [K+1];
   logic [30:0]   nm_ms_ff  [K+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_v_ff[0] <= 1'b0;
      end else if (en) begin
         nm_v_ff[0] <= g_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            nm_mag_ff[0][i] <= g_t_ff[i][TW-1] ? MW'(-g_t_ff[i]) : MW'(g_t_ff[i]);
            nm_neg_ff[0][i] <= g_t_ff[i][TW-1];
         end
         nm_ms_ff[0] <= g_ms_ff;
      end
   end

   for (genvar j = 1; j <= K; j++) begin : g_norm
      localparam int SH = 1 << (K - j);
      logic big;

      if (30 + SH <= MW - 1) begin : g_chk
         logic [MW-1:0] orv;
         assign orv = nm_mag_ff[j-1][0] | nm_mag_ff[j-1][1] | nm_mag_ff[j-1][2];
         assign big = |orv[MW-1:30+SH];
      end else begin : g_none
         assign big = 1'b0;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nm_v_ff[j] <= 1'b0;
         end else if (en) begin
            nm_v_ff[j] <= nm_v_ff[j-1];
         end
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               nm_mag_ff[j][i] <= big ? nm_mag_ff[j-1][i] >> SH : nm_mag_ff[j-1][i];
            end
            nm_neg_ff[j] <= nm_neg_ff[j-1];
            nm_ms_ff[j]  <= nm_ms_ff[j-1];
         end
      end
   end

   // Direction length.
   logic             u_v_ff;
   psv_pkg::fin_type u_fin_ff;
   logic [61:0]      u_sq_ff [3];
   logic             w_v_ff;
   psv_pkg::fin_type w_fin_ff;
   logic [63:0]      w_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         u_v_ff <= 1'b0;
         w_v_ff <= 1'b0;
      end else if (en) begin
         u_v_ff <= nm_v_ff[K];
         w_v_ff <= u_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_fin_ff.e[i] <= nm_mag_ff[K][i][30:0];
            u_sq_ff[i]    <= 62'(nm_mag_ff[K][i][30:0]) * 62'(nm_mag_ff[K][i][30:0]);
         end
         u_fin_ff.neg <= nm_neg_ff[K];
         u_fin_ff.ms  <= nm_ms_ff[K];
         w_sum_ff <= 64'(u_sq_ff[0]) + 64'(u_sq_ff[1]) + 64'(u_sq_ff[2]);
         w_fin_ff <= u_fin_ff;
      end
   end

   logic                                l_v;
   logic [31:0]                         l_root;
   logic [$bits(psv_pkg::fin_type)-1:0] l_side;
   psv_pkg::fin_type                    l_fin;

   psv_sqrt #(.XW(64), .SW($bits(psv_pkg::fin_type))) u_len (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(w_v_ff), .in_x(w_sum_ff), .in_side(w_fin_ff),
      .out_valid(l_v), .out_root(l_root), .out_side(l_side)
   );

   assign l_fin = l_side;

   // Scale each component by max speed over twice the length.
   logic             r_v_ff;
   psv_pkg::tag_type r_tag_ff;
   logic [61:0]      r_num_ff [3];
   logic [32:0]      r_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (en) begin
         r_v_ff <= l_v;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            r_num_ff[i] <= 62'(l_fin.e[i]) * 62'(l_fin.ms);
         end
         r_den_ff     <= {l_root, 1'b0};
         r_tag_ff.neg <= l_fin.neg;
         r_tag_ff.ok  <= (l_fin.ms != '0) && (l_root != '0);
      end
   end

   logic                                q_v;
   logic [61:0]                         q_quo [3];
   logic [$bits(psv_pkg::tag_type)-1:0] q_side;
   psv_pkg::tag_type                    q_tag;

   psv_div #(.NW(62), .DW(33), .SW($bits(psv_pkg::tag_type))) u_scale0 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(r_v_ff), .in_num(r_num_ff[0]), .in_den(r_den_ff), .in_side(r_tag_ff),
      .out_valid(q_v), .out_quo(q_quo[0]), .out_side(q_side)
   );

   for (genvar i = 1; i < 3; i++) begin : g_scale
      psv_div #(.NW(62), .DW(33), .SW(1)) u_scale (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(r_v_ff), .in_num(r_num_ff[i]), .in_den(r_den_ff), .in_side(1'b0),
         .out_valid(), .out_quo(q_quo[i]), .out_side()
      );
   end

   assign q_tag = q_side;

   psv_pkg::rsp_type res;
   logic [31:0]      res_vel [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!q_tag.ok) begin
            res_vel[i] = '0;
         end else if (q_tag.neg[i]) begin
            res_vel[i] = 32'(-{1'b0, q_quo[i][30:0]});
         end else begin
            res_vel[i] = {1'b0, q_quo[i][30:0]};
         end
      end
      res.steer_vel_x  = res_vel[0];
      res.steer_vel_y  = res_vel[1];
      res.steer_vel_z  = res_vel[2];
      res.result_valid = q_tag.ok;
   end

   // Output register with a skid entry; the pipeline holds while the skid entry is full.
   logic             out_v_ff;
   psv_pkg::rsp_type out_ff;
   logic             skid_v_ff;
   psv_pkg::rsp_type skid_ff;
   logic             take;
   logic             arrive;

   assign en     = !skid_v_ff;
   assign take   = out_v_ff && rsp_ready;
   assign arrive = en && q_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end else if (arrive) begin
            out_ff <= res;
         end else begin
            out_v_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (!out_v_ff) begin
            out_ff   <= res;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= res;
            skid_v_ff <= 1'b1;
         end
      end
   end

   assign req_ready   = en;
   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("Skid entry is full while the output register is empty.");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("Skid entry filled although the output item was taken.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ff.result_valid) |->
      (out_ff.steer_vel_x == '0 && out_ff.steer_vel_y == '0 && out_ff.steer_vel_z == '0))
      else $error("Item without a direction carries a nonzero velocity.");

   a_half_speed: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_ff.steer_vel_x[31] == out_ff.steer_vel_x[30] &&
                    out_ff.steer_vel_y[31] == out_ff.steer_vel_y[30] &&
                    out_ff.steer_vel_z[31] == out_ff.steer_vel_z[30]))
      else $error("Velocity component exceeds half of the speed range.");

endmodule

/* rtl/core/psv_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Carries a side vector and a valid bit along with each item; uses no package.
module psv_sqrt #(
   parameter int XW = 64,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [XW-1:0]   in_x,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [XW/2-1:0] out_root,
   output logic [SW-1:0]   out_side
);
   localparam int RW = XW / 2;

   logic          v_ff    [RW+1];
   logic [XW-1:0] x_ff    [RW+1];
   logic [RW:0]   rem_ff  [RW+1];
   logic [RW-1:0] root_ff [RW+1];
   logic [SW-1:0] side_ff [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= in_x;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RW+2:0] r_in;
      logic [RW+2:0] trial_in;
      logic          ge_in;

      assign r_in     = {rem_ff[i], x_ff[i][XW-1 -: 2]};
      assign trial_in = {1'b0, root_ff[i], 2'b01};
      assign ge_in    = r_in >= trial_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            x_ff[i+1]    <= x_ff[i] << 2;
            rem_ff[i+1]  <= ge_in ? (RW+1)'(r_in - trial_in) : (RW+1)'(r_in);
            root_ff[i+1] <= {root_ff[i][RW-2:0], ge_in};
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];

endmodule

/* rtl/core/psv_div.sv */
// Pipelined restoring divider for unsigned integers, one quotient bit per register stage.
// Carries a side vector and a valid bit along with each item; uses no package.
module psv_div #(
   parameter int NW = 62,
   parameter int DW = 33,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [SW-1:0] out_side
);
   logic          v_ff    [NW+1];
   logic [NW-1:0] n_ff    [NW+1];
   logic [DW-1:0] den_ff  [NW+1];
   logic [DW-1:0] rem_ff  [NW+1];
   logic [SW-1:0] side_ff [NW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         n_ff[0]    <= in_num;
         den_ff[0]  <= in_den;
         rem_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW:0] r_in;
      logic        ge_in;

      assign r_in  = {rem_ff[i], n_ff[i][NW-1]};
      assign ge_in = r_in >= {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            n_ff[i+1]    <= {n_ff[i][NW-2:0], ge_in};
            den_ff[i+1]  <= den_ff[i];
            rem_ff[i+1]  <= ge_in ? DW'(r_in - {1'b0, den_ff[i]}) : DW'(r_in);
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[NW];
   assign out_quo   = n_ff[NW];
   assign out_side  = side_ff[NW];

endmodule
